// ----- rtl/core/baq_pkg.sv -----
// ----------------------------------------------------------------------------
// baq_pkg
// Shared types and constants for the button auto-repeat qualifier.
// ----------------------------------------------------------------------------
package baq_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int BTN_W       = 16;
  localparam int NUM_LANES   = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
  localparam int CNT_W       = 4;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_DELAY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_PERIOD = 2'd1;

  localparam logic [CNT_W-1:0] INITIAL_DELAY_RST = 4'hc;
  localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 4'd4;

  typedef struct packed {
    logic [CNT_W-1:0] initial_delay;
    logic [CNT_W-1:0] repeat_period;
  } baq_cfg_t;

endpackage

// ----- rtl/core/baq_lane.sv -----
// ----------------------------------------------------------------------------
// baq_lane
// Repeat counter and pass decision for a single button.
// ----------------------------------------------------------------------------
module baq_lane (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             cur,
  input  logic             prev,
  input  baq_pkg::baq_cfg_t cfg,
  output logic             pass
);

  logic [baq_pkg::CNT_W-1:0] cnt_r;
  logic [baq_pkg::CNT_W-1:0] cnt_nxt;
  logic [baq_pkg::CNT_W-1:0] clamped;
  logic                      changed;
  logic                      at_zero;

  always_comb begin
    changed = cur ^ prev;
    clamped = (cnt_r > cfg.initial_delay) ? cfg.initial_delay : cnt_r;
    at_zero = (clamped == '0);
    if (changed) begin
      cnt_nxt = cfg.initial_delay;
    end else if (at_zero) begin
      cnt_nxt = cfg.repeat_period;
    end else begin
      cnt_nxt = clamped - 1'b1;
    end
    pass = changed | at_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/baq_merge.sv -----
// ----------------------------------------------------------------------------
// baq_merge
// Combines the lane decisions into the two masks and holds the result item.
// ----------------------------------------------------------------------------
module baq_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [baq_pkg::BTN_W-1:0]  cur,
  input  logic [baq_pkg::BTN_W-1:0]  prev,
  input  logic [baq_pkg::BTN_W-1:0]  pass,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [2*baq_pkg::BTN_W-1:0] out_tdata
);

  logic                        valid_r;
  logic [2*baq_pkg::BTN_W-1:0] data_r;
  logic [baq_pkg::BTN_W-1:0]   pressed;
  logic [baq_pkg::BTN_W-1:0]   held;

  always_comb begin
    pressed = ~prev & cur;
    held    = cur & pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {held, pressed};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- rtl/core/button_autorepeat_qualifier_unit.sv -----
// ----------------------------------------------------------------------------
// button_autorepeat_qualifier_unit
// Edge and auto-repeat qualification of a button sample, one lane per button.
//
//   Channel  Direction  Payload (low bits first)
//   in_      slave      tdata: cur_buttons[15:0]
//   out_     master     tdata: pressed_mask[15:0], held_mask[15:0]
//   cfg_     write      addr 0 initial_delay, addr 1 repeat_period
//
// One item per cycle while the output is not stalled; the result appears in the
// cycle after acceptance, held in the single output register behind the lane counters.
// Reset is synchronous and clears the counters, the previous sample and the
// configuration to its defaults.
// Input is taken whenever the output register is empty or being drained.
// ----------------------------------------------------------------------------
module button_autorepeat_qualifier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [baq_pkg::BTN_W-1:0]         in_tdata,   // cur_buttons
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*baq_pkg::BTN_W-1:0]       out_tdata,  // pressed_mask, held_mask
  input  logic                              cfg_we,
  input  logic [baq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [baq_pkg::CNT_W-1:0]         cfg_wdata
);

  baq_pkg::baq_cfg_t             cfg_r;
  logic [baq_pkg::BTN_W-1:0]     prev_r;
  logic [baq_pkg::BTN_W-1:0]     cur;
  logic [baq_pkg::BTN_W-1:0]     pass;
  logic                          accept;

  assign in_tready = ~out_tvalid | out_tready;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    cur = '0;
    for (int i = 0; i < baq_pkg::NUM_LANES; i++) begin
      cur[i] = in_tdata[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_delay <= baq_pkg::INITIAL_DELAY_RST;
      cfg_r.repeat_period <= baq_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        baq_pkg::CFG_INITIAL_DELAY: cfg_r.initial_delay <= cfg_wdata;
        baq_pkg::CFG_REPEAT_PERIOD: cfg_r.repeat_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (accept) begin
      prev_r <= cur;
    end
  end

  for (genvar g = 0; g < baq_pkg::BTN_W; g++) begin : g_lane
    if (g < baq_pkg::NUM_LANES) begin : g_on
      baq_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .cur   (cur[g]),
        .prev  (prev_r[g]),
        .cfg   (cfg_r),
        .pass  (pass[g])
      );
    end else begin : g_off
      assign pass[g] = 1'b0;
    end
  end

  baq_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .cur        (cur),
    .prev       (prev_r),
    .pass       (pass),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted item produced no result");

  a_pressed_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[baq_pkg::BTN_W-1:0]
                     & ~out_tdata[2*baq_pkg::BTN_W-1:baq_pkg::BTN_W]) == '0))
    else $error("pressed button missing from held mask");

  a_prev_tracks_input: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (prev_r == $past(cur)))
    else $error("previous sample not updated");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !accept)
    else $error("item accepted while result stalled");

endmodule

// ----- sim/tb_button_autorepeat_qualifier_unit.sv -----
// ----------------------------------------------------------------------------
// tb_button_autorepeat_qualifier_unit
// Self-checking bench for the button auto-repeat qualifier.
//
// A shadow copy of the previous sample, the per-button countdowns and both
// settings predicts the pressed and held masks of every accepted item. The
// bench compares each result against the oldest prediction. Directed items
// cover the extreme patterns, zero delay and period, and writes to unused
// register indexes. Random phases under several settings then hold most
// buttons steady for long runs so that auto-repeat fires, with sparse
// toggles and some full-random noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_button_autorepeat_qualifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [baq_pkg::CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [baq_pkg::CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int PHASE_ITEMS = 150;

  typedef logic [baq_pkg::BTN_W-1:0] buttons_t;
  typedef logic [baq_pkg::CNT_W-1:0] setting_t;

  typedef struct packed {
    logic [baq_pkg::BTN_W-1:0] held;
    logic [baq_pkg::BTN_W-1:0] pressed;
  } masks_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [baq_pkg::BTN_W-1:0]      in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [2*baq_pkg::BTN_W-1:0]    out_tdata;
  logic                           cfg_we;
  logic [baq_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [baq_pkg::CNT_W-1:0]      cfg_wdata;

  logic [baq_pkg::CNT_W-1:0] delay_setting;
  logic [baq_pkg::CNT_W-1:0] period_setting;
  logic [baq_pkg::BTN_W-1:0] last_sample;
  logic [baq_pkg::CNT_W-1:0] countdown [baq_pkg::NUM_LANES];

  masks_t expected_masks [$];
  int     mismatches;
  int     results_seen;
  int     burst_left;
  int     ready_run;
  bit     tx_steady;
  bit     rx_steady;

  button_autorepeat_qualifier_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic masks_t qualify_sample(input logic [baq_pkg::BTN_W-1:0] cur);
    masks_t                    r;
    logic [baq_pkg::CNT_W-1:0] c;
    r.pressed = ~last_sample & cur;
    r.held    = cur;
    for (int i = 0; i < baq_pkg::NUM_LANES; i++) begin
      c = countdown[i];
      if (cur[i] != last_sample[i]) begin
        c = delay_setting;
      end else begin
        if (c > delay_setting) c = delay_setting;
        if (c == '0) begin
          c = period_setting;
        end else begin
          c = c - 1'b1;
          r.held[i] = 1'b0;
        end
      end
      countdown[i] = c;
    end
    last_sample = cur;
    return r;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [baq_pkg::BTN_W-1:0] got,
                                 input logic [baq_pkg::BTN_W-1:0] want);
    $display("[%0t] MISMATCH %s in result %0d: got %h, expected %h",
             $time, what, results_seen, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    masks_t got;
    masks_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_masks.size() == 0) begin
        report_mismatch("unexpected item", got.pressed, '0);
      end else begin
        want = expected_masks.pop_front();
        if (got.pressed !== want.pressed) report_mismatch("pressed_mask", got.pressed,
                                                          want.pressed);
        if (got.held !== want.held) report_mismatch("held_mask", got.held, want.held);
      end
      results_seen++;
    end
  end

  always @(negedge clk) begin
    if (rx_steady) begin
      out_tready <= 1'b1;
    end else if (ready_run == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        ready_run = $urandom_range(1, 12);
      end else begin
        out_tready <= 1'b0;
        ready_run = $urandom_range(1, 6);
      end
    end else begin
      ready_run--;
    end
  end

  task automatic send_buttons(input logic [baq_pkg::BTN_W-1:0] buttons);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= buttons;
    do @(posedge clk); while (!in_tready);
    expected_masks.push_back(qualify_sample(buttons));
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [baq_pkg::CFG_ADDR_W-1:0] idx,
                                input logic [baq_pkg::CNT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      baq_pkg::CFG_INITIAL_DELAY: delay_setting  = value;
      baq_pkg::CFG_REPEAT_PERIOD: period_setting = value;
      default: ;
    endcase
  endtask

  task automatic test_edges_after_reset();
    send_buttons(16'h0000);
    send_buttons(16'hFFFF);
    send_buttons(16'hFFFF);
    send_buttons(16'h0000);
    send_buttons(16'hA5A5);
    send_buttons(16'h5A5A);
    send_buttons(16'h8001);
    send_buttons(16'h8001);
  endtask

  // A zero delay makes every steady frame reload and pass; a zero period
  // lets a held button through on every frame.
  task automatic test_zero_settings();
    write_register(baq_pkg::CFG_INITIAL_DELAY, 4'd0);
    write_register(baq_pkg::CFG_REPEAT_PERIOD, 4'd0);
    send_buttons(16'hFFFF);
    send_buttons(16'hFFFF);
    send_buttons(16'hFFFF);
    send_buttons(16'h0F0F);
  endtask

  task automatic test_spare_indexes();
    write_register(CFG_SPARE_2, 4'hF);
    write_register(CFG_SPARE_3, 4'hF);
    send_buttons(16'h0F0F);
    send_buttons(16'h0F0F);
  endtask

  // Counters loaded at the top delay are clamped once the delay drops.
  task automatic test_clamp_and_repeat();
    write_register(baq_pkg::CFG_INITIAL_DELAY, 4'd15);
    write_register(baq_pkg::CFG_REPEAT_PERIOD, 4'd15);
    send_buttons(16'h00FF);
    send_buttons(16'h00FF);
    write_register(baq_pkg::CFG_INITIAL_DELAY, 4'd1);
    write_register(baq_pkg::CFG_REPEAT_PERIOD, 4'd2);
    repeat (5) send_buttons(16'h00FF);
  endtask

  task automatic test_random_phases();
    int                        phase_delay  [9] = '{1, 15, 0, 15, 1, 3, -1, -1, -1};
    int                        phase_period [9] = '{0, 15, 0, 0, 15, 2, -1, -1, -1};
    logic [baq_pkg::BTN_W-1:0] level;
    logic [baq_pkg::BTN_W-1:0] movers;
    int                        pick;
    level = buttons_t'($urandom);
    for (int p = 0; p < 9; p++) begin
      write_register(baq_pkg::CFG_INITIAL_DELAY,
                     setting_t'((phase_delay[p] < 0) ? $urandom_range(1, 15)
                                                     : phase_delay[p]));
      write_register(baq_pkg::CFG_REPEAT_PERIOD,
                     setting_t'((phase_period[p] < 0) ? $urandom_range(0, 15)
                                                      : phase_period[p]));
      tx_steady = (p == 2 || p == 7);
      rx_steady = (p == 3 || p == 7);
      movers = buttons_t'($urandom & $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
        pick = $urandom_range(0, 9);
        if (pick == 0) level = buttons_t'($urandom);
        else if (pick > 1) level = level ^ (buttons_t'($urandom & $urandom) & movers);
        send_buttons(level);
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = baq_pkg::CFG_INITIAL_DELAY;
    cfg_wdata      = '0;
    delay_setting  = baq_pkg::INITIAL_DELAY_RST;
    period_setting = baq_pkg::REPEAT_PERIOD_RST;
    last_sample    = '0;
    for (int i = 0; i < baq_pkg::NUM_LANES; i++) countdown[i] = '0;
    mismatches     = 0;
    results_seen   = 0;
    burst_left     = 0;
    ready_run      = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edges_after_reset();
    test_zero_settings();
    test_spare_indexes();
    test_clamp_and_repeat();
    test_random_phases();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
